// ===== design/ptpd_pkg.sv =====
// Package for the planar tile pixel decoder.
// Holds sizes, derived widths, action and register codes and the state type.
// No dependencies.
`default_nettype none

package ptpd_pkg;

	// Store and table sizes (STORE_BYTES must be a power of two: bit addresses wrap)
	localparam int STORE_BYTES  = 65536;
	localparam int MAX_TILE_DIM = 32;
	localparam int MAX_PLANES   = 8;
	localparam int MAX_TILES    = 1024;

	// Field widths
	localparam int ACTION_W  = 3;
	localparam int INDEX_W   = 5;
	localparam int OFFSET_W  = 19;
	localparam int RAW_ADDR_W = 16;
	localparam int BYTE_W    = 8;
	localparam int TILE_W    = 10;
	localparam int COORD_W   = 5;
	localparam int FLIP_W    = 2;
	localparam int PIX_W     = 8;

	// Configuration register widths
	localparam int TW_W     = 6;
	localparam int TH_W     = 6;
	localparam int BPP_W    = 4;
	localparam int TCOUNT_W = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 19;

	// Derived widths
	localparam int STORE_ADDR_W = $clog2(STORE_BYTES);
	localparam int BIT_ADDR_W   = STORE_ADDR_W + 3;
	localparam int PLANE_IDX_W  = $clog2(MAX_PLANES);
	localparam int PLANE_CNT_W  = $clog2(MAX_PLANES + 1);
	localparam int DIM_IDX_W    = $clog2(MAX_TILE_DIM);

	// Input actions
	typedef enum logic [ACTION_W-1:0] {
		ACT_PLANE_OFF  = 3'd0,
		ACT_COLUMN_OFF = 3'd1,
		ACT_ROW_OFF    = 3'd2,
		ACT_RAW_WRITE  = 3'd3,
		ACT_QUERY      = 3'd4
	} action_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TILE_WIDTH  = 3'd0,
		CFG_TILE_HEIGHT = 3'd1,
		CFG_BPP         = 3'd2,
		CFG_TILE_COUNT  = 3'd3,
		CFG_TILE_STRIDE = 3'd4
	} cfg_index_t;

	// Query sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MULT,
		S_SUM,
		S_READ,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== design/ptpd_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the raw graphics store of the decoder. No dependencies.
`default_nettype none

module ptpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/planar_tile_pixel_decoder_unit.sv =====
// Planar bitplane tile pixel decoder, top level.
// Uses ptpd_pkg and one ptpd_ram instance for the raw graphics store.
// Input channel (in_valid/in_ready): one item per transfer, a plane, column or row
//   offset table write, a raw store byte write, or a pixel query. Writes complete
//   in the transfer cycle, give no result and are taken every cycle while idle.
// Output channel (out_valid/out_ready): one result per query, the colour index with
//   plane 0 as its top bit, and an out-of-range flag.
// Query steps from transfer to out_valid: multiply, address sum, one store read per
//   bitplane with its registered read data, result load; an out-of-range query goes
//   straight to the result load. The single store read port, one bitplane per cycle,
//   sets the pace. One query is in flight at a time and in_ready is high only while
//   idle, so the next item is taken only after a query has loaded its result.
// A waiting result sits in an output register and new items are still taken; a
//   following query holds in its last step until the register frees.
// Reset clears the offset tables and loads 8x8 tiles, 2 planes, 256 tiles and a
//   128-bit stride; the raw store is not cleared and holds nothing until written.
// Configuration (cfg_write_enable/cfg_index/cfg_data) must be written only while idle; the block does not enforce it.
`default_nettype none

module planar_tile_pixel_decoder_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_write_enable,
	input  wire logic [ptpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ptpd_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [ptpd_pkg::ACTION_W-1:0]       action,
	input  wire logic [ptpd_pkg::INDEX_W-1:0]        table_index,
	input  wire logic [ptpd_pkg::OFFSET_W-1:0]       offset_value,
	input  wire logic [ptpd_pkg::RAW_ADDR_W-1:0]     raw_address,
	input  wire logic [ptpd_pkg::BYTE_W-1:0]         raw_byte,
	input  wire logic [ptpd_pkg::TILE_W-1:0]         tile,
	input  wire logic [ptpd_pkg::COORD_W-1:0]        pixel_x,
	input  wire logic [ptpd_pkg::COORD_W-1:0]        pixel_y,
	input  wire logic [ptpd_pkg::FLIP_W-1:0]         flip,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [ptpd_pkg::PIX_W-1:0]          pixel_value,
	output logic                                     query_out_of_range
);

	localparam int BA_W = ptpd_pkg::BIT_ADDR_W;
	localparam int DIM_IDX_W_L = ptpd_pkg::DIM_IDX_W;

	// Configuration registers
	logic [ptpd_pkg::TW_W-1:0]       tile_width_q;
	logic [ptpd_pkg::TH_W-1:0]       tile_height_q;
	logic [ptpd_pkg::BPP_W-1:0]      bpp_q;
	logic [ptpd_pkg::TCOUNT_W-1:0]   tile_count_q;
	logic [ptpd_pkg::OFFSET_W-1:0]   stride_q;

	// Offset tables
	logic [ptpd_pkg::OFFSET_W-1:0] plane_off_q  [ptpd_pkg::MAX_PLANES];
	logic [ptpd_pkg::OFFSET_W-1:0] column_off_q [ptpd_pkg::MAX_TILE_DIM];
	logic [ptpd_pkg::OFFSET_W-1:0] row_off_q    [ptpd_pkg::MAX_TILE_DIM];

	// Sequencer and query registers
	ptpd_pkg::state_t                state_q, state_d;
	logic [ptpd_pkg::TILE_W-1:0]     tile_q;
	logic [DIM_IDX_W_L-1:0]          x_q, y_q;
	logic                            oor_q;
	logic [ptpd_pkg::PLANE_CNT_W-1:0] planes_q;
	logic [ptpd_pkg::PLANE_CNT_W-1:0] issue_q;
	logic [BA_W-1:0]                 prod_q, col_q, row_q, base_q;
	logic                            rd_pend_s1;
	logic [2:0]                      bit_sel_s1;
	logic [ptpd_pkg::PIX_W-1:0]      pix_q;

	// Output register
	logic                            out_valid_q;
	logic [ptpd_pkg::PIX_W-1:0]      out_pix_q;
	logic                            out_oor_q;

	// Control outputs of the sequencer
	logic                            in_xfer;
	logic                            ram_re;
	logic                            out_load;
	logic                            is_query;

	// Store port signals
	logic [ptpd_pkg::BYTE_W-1:0]     rd_data;
	logic [BA_W-1:0]                 rd_bit_addr;

	// Query decode at transfer
	logic [ptpd_pkg::TW_W-1:0]       w_sat, h_sat;
	logic [ptpd_pkg::BPP_W-1:0]      planes_sat;
	logic [ptpd_pkg::TCOUNT_W-1:0]   tiles_sat;
	logic                            oor_in;
	logic [ptpd_pkg::TW_W-1:0]       x_flip, y_flip;

	// Saturate sizes and range-check the incoming query
	always_comb begin
		w_sat = (tile_width_q > ptpd_pkg::TW_W'(ptpd_pkg::MAX_TILE_DIM))
			? ptpd_pkg::TW_W'(ptpd_pkg::MAX_TILE_DIM) : tile_width_q;
		h_sat = (tile_height_q > ptpd_pkg::TH_W'(ptpd_pkg::MAX_TILE_DIM))
			? ptpd_pkg::TH_W'(ptpd_pkg::MAX_TILE_DIM) : tile_height_q;
		planes_sat = (bpp_q > ptpd_pkg::BPP_W'(ptpd_pkg::MAX_PLANES))
			? ptpd_pkg::BPP_W'(ptpd_pkg::MAX_PLANES) : bpp_q;
		tiles_sat = (tile_count_q > ptpd_pkg::TCOUNT_W'(ptpd_pkg::MAX_TILES))
			? ptpd_pkg::TCOUNT_W'(ptpd_pkg::MAX_TILES) : tile_count_q;
		oor_in = (ptpd_pkg::TCOUNT_W'(tile) >= tiles_sat)
			|| (ptpd_pkg::TW_W'(pixel_x) >= w_sat)
			|| (ptpd_pkg::TH_W'(pixel_y) >= h_sat);
		// mirror inside the configured tile size
		x_flip = flip[0] ? (w_sat - 6'd1 - ptpd_pkg::TW_W'(pixel_x)) : ptpd_pkg::TW_W'(pixel_x);
		y_flip = flip[1] ? (h_sat - 6'd1 - ptpd_pkg::TH_W'(pixel_y)) : ptpd_pkg::TH_W'(pixel_y);
	end

	assign in_xfer  = in_valid && in_ready;
	assign is_query = (action == ptpd_pkg::ACT_QUERY);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptpd_pkg::S_IDLE: begin
				if (in_xfer && is_query) begin
					state_d = oor_in ? ptpd_pkg::S_DONE : ptpd_pkg::S_MULT;
				end
			end
			ptpd_pkg::S_MULT: state_d = ptpd_pkg::S_SUM;
			ptpd_pkg::S_SUM:  state_d = ptpd_pkg::S_READ;
			ptpd_pkg::S_READ: begin
				if (issue_q == planes_q && !rd_pend_s1) begin
					state_d = ptpd_pkg::S_DONE;
				end
			end
			ptpd_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ptpd_pkg::S_IDLE;
				end
			end
			default: state_d = ptpd_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ptpd_pkg::S_IDLE: in_ready = 1'b1;
			ptpd_pkg::S_READ: ram_re   = (issue_q != planes_q);
			ptpd_pkg::S_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptpd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= 6'd8;
			tile_height_q <= 6'd8;
			bpp_q         <= 4'd2;
			tile_count_q  <= 11'd256;
			stride_q      <= 19'd128;
		end else if (cfg_write_enable) begin
			case (cfg_index)
				ptpd_pkg::CFG_TILE_WIDTH:  tile_width_q  <= cfg_data[ptpd_pkg::TW_W-1:0];
				ptpd_pkg::CFG_TILE_HEIGHT: tile_height_q <= cfg_data[ptpd_pkg::TH_W-1:0];
				ptpd_pkg::CFG_BPP:         bpp_q         <= cfg_data[ptpd_pkg::BPP_W-1:0];
				ptpd_pkg::CFG_TILE_COUNT:  tile_count_q  <= cfg_data[ptpd_pkg::TCOUNT_W-1:0];
				ptpd_pkg::CFG_TILE_STRIDE: stride_q      <= cfg_data[ptpd_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Offset table writes; drop indexes beyond a table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptpd_pkg::MAX_PLANES; i++) begin
				plane_off_q[i] <= '0;
			end
			for (int i = 0; i < ptpd_pkg::MAX_TILE_DIM; i++) begin
				column_off_q[i] <= '0;
				row_off_q[i]    <= '0;
			end
		end else if (in_xfer) begin
			case (action)
				ptpd_pkg::ACT_PLANE_OFF: begin
					if (32'(table_index) < ptpd_pkg::MAX_PLANES) begin
						plane_off_q[table_index[ptpd_pkg::PLANE_IDX_W-1:0]] <= offset_value;
					end
				end
				ptpd_pkg::ACT_COLUMN_OFF: begin
					if (32'(table_index) < ptpd_pkg::MAX_TILE_DIM) begin
						column_off_q[table_index[DIM_IDX_W_L-1:0]] <= offset_value;
					end
				end
				ptpd_pkg::ACT_ROW_OFF: begin
					if (32'(table_index) < ptpd_pkg::MAX_TILE_DIM) begin
						row_off_q[table_index[DIM_IDX_W_L-1:0]] <= offset_value;
					end
				end
				default: ;
			endcase
		end
	end

	// Capture the query, then form the base bit address over two steps
	always_ff @(posedge clk) begin
		if (in_xfer && is_query) begin
			tile_q   <= tile;
			x_q      <= x_flip[DIM_IDX_W_L-1:0];
			y_q      <= y_flip[DIM_IDX_W_L-1:0];
			oor_q    <= oor_in;
			planes_q <= ptpd_pkg::PLANE_CNT_W'(planes_sat);
			pix_q    <= '0;
		end
		if (state_q == ptpd_pkg::S_MULT) begin
			prod_q  <= BA_W'(tile_q * stride_q);
			col_q   <= BA_W'(column_off_q[x_q]);
			row_q   <= BA_W'(row_off_q[y_q]);
		end
		if (state_q == ptpd_pkg::S_SUM) begin
			base_q  <= prod_q + row_q + col_q;
		end
		// shift in one plane bit per returned byte, MSB of the byte first
		if (rd_pend_s1) begin
			pix_q <= {pix_q[ptpd_pkg::PIX_W-2:0], rd_data[~bit_sel_s1]};
		end
		if (ram_re) begin
			bit_sel_s1 <= rd_bit_addr[2:0];
		end
	end

	// Plane issue counter and read-pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= ram_re;
			if (state_q == ptpd_pkg::S_SUM) begin
				issue_q <= '0;
			end else if (ram_re) begin
				issue_q <= issue_q + 1'b1;
			end
		end
	end

	assign rd_bit_addr = base_q + BA_W'(plane_off_q[issue_q[ptpd_pkg::PLANE_IDX_W-1:0]]);

	// Raw graphics store
	ptpd_ram #(
		.WIDTH(ptpd_pkg::BYTE_W),
		.DEPTH(ptpd_pkg::STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (in_xfer && action == ptpd_pkg::ACT_RAW_WRITE),
		.waddr(ptpd_pkg::STORE_ADDR_W'(raw_address)),
		.wdata(raw_byte),
		.re   (ram_re),
		.raddr(rd_bit_addr[BA_W-1:3]),
		.rdata(rd_data)
	);

	// Output register: load on completion, clear on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q <= oor_q ? '0 : pix_q;
			out_oor_q <= oor_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign pixel_value        = out_pix_q;
	assign query_out_of_range = out_oor_q;

endmodule

`default_nettype wire
